/* design/twtrl_pkg.sv */
package twtrl_pkg;

    localparam int RANGE      = 4;
    localparam int COORD_BITS = 16;

    localparam int SIDE    = 2 * RANGE;
    localparam int ENTRIES = SIDE * SIDE;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SIDE_W  = $clog2(SIDE);
    localparam int MOV_W   = $clog2(ENTRIES + 1);
    localparam int ENTRY_W = 2 * COORD_BITS;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ENTRY_W-1:0]           entry_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [SIDE_W-1:0]            side_t;
    typedef logic [MOV_W-1:0]             moved_t;

    typedef enum logic
    {
        ACT_RECENTER = 1'b0,
        ACT_LOOKUP   = 1'b1
    } action_t;

    typedef enum logic [2:0]
    {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

endpackage

/* design/tile_window_table_recenter_lookup.sv */
// Tile window table: a (2*RANGE)^2-entry table of tile coordinate pairs kept in a
// simple dual-port synchronous RAM (one read and one write per cycle). A recenter beat
// (tuser = 0) relocates every entry outside the window around the camera tile to the
// opposite edge and reports how many moved; a lookup beat (tuser = 1) floors the world
// position to its tile (>> 4), searches for the highest matching index and returns it
// with the in-tile offset. Every beat sweeps all entries, one RAM read per cycle from
// the top index down, with a registered RAM read feeding a read-modify-write stage.
// An input beat is followed by ENTRIES reads, the modify/write of the last entry and
// the load of the output register. The slave side is ready again from the edge that
// loads the output register, so a new beat is accepted only once the previous sweep
// is through; the sweep over the RAM read port is what limits the beat rate. The result
// register lets a new beat be accepted while the previous result waits on m_axis_tready;
// the load of the next result then waits until that one is taken.
// The table's reset grid comes from per-entry valid flops, so no clearing pass runs
// after reset. Tile coordinates wrap at COORD_BITS bits and compare as signed values.
module tile_window_table_recenter_lookup
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] cam_tile_x, [31:16] cam_tile_z, [51:32] world_x, [71:52] world_z
    input  logic [twtrl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] action
    input  logic                             s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] found, [6:1] entry_index, [10:7] local_x, [14:11] local_z,
    // [21:15] moved_count, [23:22] zero
    output logic [twtrl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    twtrl_pkg::state_t state_reg;

    // beat fields
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_z;
    logic signed [19:0] world_x;
    logic signed [19:0] world_z;

    assign cam_x   = s_axis_tdata[15:0];
    assign cam_z   = s_axis_tdata[31:16];
    assign world_x = s_axis_tdata[51:32];
    assign world_z = s_axis_tdata[71:52];

    logic in_beat;
    assign s_axis_tready = (state_reg == twtrl_pkg::ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // latched command
    twtrl_pkg::action_t act_reg;
    twtrl_pkg::coord_t  cx_reg;
    twtrl_pkg::coord_t  cz_reg;
    twtrl_pkg::coord_t  tx_reg;
    twtrl_pkg::coord_t  tz_reg;
    logic [3:0]         lx_reg;
    logic [3:0]         lz_reg;

    // read issue side
    logic              issue_reg;
    twtrl_pkg::idx_t   cnt_reg;
    twtrl_pkg::side_t  col_reg;
    twtrl_pkg::side_t  row_reg;

    // modify/write stage (data arrives from RAM this cycle)
    logic              p_vld_reg;
    logic              p_last_reg;
    twtrl_pkg::idx_t   p_idx_reg;
    twtrl_pkg::side_t  p_col_reg;
    twtrl_pkg::side_t  p_row_reg;

    // table RAM and per-entry written flags
    twtrl_pkg::entry_t             mem [twtrl_pkg::ENTRIES];
    twtrl_pkg::entry_t             rd_data_reg;
    logic                          rd_vld_reg;
    logic [twtrl_pkg::ENTRIES-1:0] written_reg;

    // accumulated result
    logic              hit_reg;
    twtrl_pkg::idx_t   hit_idx_reg;
    twtrl_pkg::moved_t moved_reg;

    logic              rd_en;
    assign rd_en = (state_reg == twtrl_pkg::ST_RUN) && issue_reg;

    // result register free (or being drained) while the sweep is done
    logic              out_load;
    assign out_load = (state_reg == twtrl_pkg::ST_FIN) && (!m_axis_tvalid || m_axis_tready);

    // ---------------- entry evaluation ----------------
    twtrl_pkg::coord_t ex;
    twtrl_pkg::coord_t ez;
    twtrl_pkg::coord_t zhi;
    twtrl_pkg::coord_t zlo;
    twtrl_pkg::coord_t xhi;
    twtrl_pkg::coord_t xlo;
    twtrl_pkg::coord_t new_x;
    twtrl_pkg::coord_t new_z;
    logic              moved;
    logic              match;
    logic              wr_en;

    assign zhi = cz_reg + twtrl_pkg::coord_t'(twtrl_pkg::RANGE);
    assign zlo = cz_reg - twtrl_pkg::coord_t'(twtrl_pkg::RANGE);
    assign xhi = cx_reg + twtrl_pkg::coord_t'(twtrl_pkg::RANGE);
    assign xlo = cx_reg - twtrl_pkg::coord_t'(twtrl_pkg::RANGE);

    always_comb
    begin
        // an entry never written still holds its reset grid position
        if (rd_vld_reg)
        begin
            ex = rd_data_reg[twtrl_pkg::COORD_BITS-1:0];
            ez = rd_data_reg[twtrl_pkg::ENTRY_W-1:twtrl_pkg::COORD_BITS];
        end
        else
        begin
            ex = twtrl_pkg::coord_t'(p_col_reg) - twtrl_pkg::coord_t'(twtrl_pkg::RANGE);
            ez = twtrl_pkg::coord_t'(p_row_reg) - twtrl_pkg::coord_t'(twtrl_pkg::RANGE);
        end

        new_x = ex;
        new_z = ez;
        moved = 1'b1;
        // first matching rule only: z high, z low, x high, x low
        if (ez > zhi)
        begin
            new_z = cz_reg - twtrl_pkg::coord_t'(twtrl_pkg::RANGE - 1);
        end
        else if (ez < zlo)
        begin
            new_z = cz_reg + twtrl_pkg::coord_t'(twtrl_pkg::RANGE - 1);
        end
        else if (ex > xhi)
        begin
            new_x = cx_reg - twtrl_pkg::coord_t'(twtrl_pkg::RANGE - 1);
        end
        else if (ex < xlo)
        begin
            new_x = cx_reg + twtrl_pkg::coord_t'(twtrl_pkg::RANGE - 1);
        end
        else
        begin
            moved = 1'b0;
        end

        match = (ex == tx_reg) && (ez == tz_reg);
    end

    assign wr_en = p_vld_reg && (act_reg == twtrl_pkg::ACT_RECENTER);

    // ---------------- RAM ----------------
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[cnt_reg];
        end
        if (wr_en)
        begin
            mem[p_idx_reg] <= {new_z, new_x};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg <= written_reg[cnt_reg];
            end
            if (wr_en)
            begin
                written_reg[p_idx_reg] <= 1'b1;
            end
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= twtrl_pkg::ST_IDLE;
            issue_reg     <= 1'b0;
            p_vld_reg     <= 1'b0;
            p_last_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            moved_reg     <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_axis_tvalid <= 1'b1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                m_axis_tvalid <= 1'b0;
            end

            case (state_reg)
                twtrl_pkg::ST_IDLE:
                begin
                    p_vld_reg <= 1'b0;
                    if (in_beat)
                    begin
                        state_reg <= twtrl_pkg::ST_RUN;
                        issue_reg <= 1'b1;
                        hit_reg   <= 1'b0;
                        moved_reg <= '0;
                    end
                end

                twtrl_pkg::ST_RUN:
                begin
                    p_vld_reg  <= issue_reg;
                    p_last_reg <= issue_reg && (cnt_reg == '0);
                    if (cnt_reg == '0)
                    begin
                        issue_reg <= 1'b0;
                    end

                    if (p_vld_reg)
                    begin
                        if (act_reg == twtrl_pkg::ACT_RECENTER)
                        begin
                            if (moved)
                            begin
                                moved_reg <= moved_reg + twtrl_pkg::moved_t'(1);
                            end
                        end
                        else if (match && !hit_reg)
                        begin
                            hit_reg <= 1'b1;
                        end
                        if (p_last_reg)
                        begin
                            state_reg <= twtrl_pkg::ST_FIN;
                        end
                    end
                end

                twtrl_pkg::ST_FIN:
                begin
                    p_vld_reg <= 1'b0;
                    if (out_load)
                    begin
                        state_reg <= twtrl_pkg::ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= twtrl_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // payload and counters
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            act_reg <= twtrl_pkg::action_t'(s_axis_tuser);
            cx_reg  <= twtrl_pkg::coord_t'(cam_x);
            cz_reg  <= twtrl_pkg::coord_t'(cam_z);
            // floor divide by 16 = arithmetic shift
            tx_reg  <= twtrl_pkg::coord_t'($signed(world_x[19:4]));
            tz_reg  <= twtrl_pkg::coord_t'($signed(world_z[19:4]));
            lx_reg  <= world_x[3:0];
            lz_reg  <= world_z[3:0];
            cnt_reg <= twtrl_pkg::idx_t'(twtrl_pkg::ENTRIES - 1);
            col_reg <= twtrl_pkg::side_t'(twtrl_pkg::SIDE - 1);
            row_reg <= twtrl_pkg::side_t'(twtrl_pkg::SIDE - 1);
        end
        else if (rd_en)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - twtrl_pkg::idx_t'(1);
            end
            if (col_reg == '0)
            begin
                col_reg <= twtrl_pkg::side_t'(twtrl_pkg::SIDE - 1);
                row_reg <= row_reg - twtrl_pkg::side_t'(1);
            end
            else
            begin
                col_reg <= col_reg - twtrl_pkg::side_t'(1);
            end
        end

        if (rd_en)
        begin
            p_idx_reg <= cnt_reg;
            p_col_reg <= col_reg;
            p_row_reg <= row_reg;
        end

        if (state_reg == twtrl_pkg::ST_IDLE)
        begin
            hit_idx_reg <= '0;
        end
        else if (p_vld_reg && (act_reg == twtrl_pkg::ACT_LOOKUP) && match && !hit_reg)
        begin
            hit_idx_reg <= p_idx_reg;
        end

        if (out_load)
        begin
            if (act_reg == twtrl_pkg::ACT_LOOKUP)
            begin
                m_axis_tdata <= {2'b00, 7'd0, lz_reg, lx_reg, 6'(hit_idx_reg), hit_reg};
            end
            else
            begin
                m_axis_tdata <= {2'b00, 7'(moved_reg), 4'd0, 4'd0, 6'd0, 1'b0};
            end
        end
    end

    // ---------------- assertions ----------------
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == twtrl_pkg::ST_RUN) && issue_reg)
        else $error("sweep did not start after input beat");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == twtrl_pkg::ST_IDLE) |-> !wr_en)
        else $error("table write while idle");

    a_moved_bound: assert property (@(posedge clk) disable iff (!rst_n)
        moved_reg <= twtrl_pkg::moved_t'(twtrl_pkg::ENTRIES))
        else $error("moved count beyond table size");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[6:1] == 6'd0))
        else $error("nonzero index on a miss");

    a_lookup_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[21:15] == 7'd0))
        else $error("moved count on a lookup hit");

endmodule
